// ===== design/scar_pkg.sv =====
// Shared types, constants and fixed-point helpers for the stereo comb/allpass reverb.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package scar_pkg;

  localparam int INNER_W    = 24;
  localparam int LINE_W     = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int MONO_GAIN  = 983;
  localparam int MAX_BASE   = 1617;

  localparam int COMB_BASE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int AP_BASE   [4] = '{556, 441, 341, 225};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOM      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_CROSS = 8'd3;

  localparam logic [CFG_DATA_W-1:0] ROOM_RESET      = 16'd55050;
  localparam logic [CFG_DATA_W-1:0] DAMPING_RESET   = 16'd13107;
  localparam logic [CFG_DATA_W-1:0] WET_MAIN_RESET  = 16'd24576;
  localparam logic [CFG_DATA_W-1:0] WET_CROSS_RESET = 16'd0;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR,
    OP_CRD, OP_CM1, OP_CM2, OP_CM3, OP_CM4, OP_CWR,
    OP_SAT, OP_ARD, OP_AWR,
    OP_MX1, OP_MX2, OP_MX3, OP_MX4, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [LINE_W-1:0]   line;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } dp_status_t;

  // Delay length of a line: combs first (left, right), then allpasses.
  function automatic int line_len(input int line, input int c, input int a, input int s);
    int r;
    if (line < c) r = COMB_BASE[line & 7];
    else if (line < 2 * c) r = COMB_BASE[(line - c) & 7] + s;
    else if (line < 2 * c + a) r = AP_BASE[(line - 2 * c) & 3];
    else r = AP_BASE[(line - 2 * c - a) & 3] + s;
    return r;
  endfunction

  function automatic int comb_total(input int c, input int s);
    int t;
    t = 0;
    for (int i = 0; i < 2 * c; i++) t += line_len(i, c, 1, s);
    return t;
  endfunction

  function automatic int ap_total(input int c, input int a, input int s);
    int t;
    t = 0;
    for (int i = 2 * c; i < 2 * c + 2 * a; i++) t += line_len(i, c, a, s);
    return t;
  endfunction

  function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [47:0] v);
    logic signed [INNER_W-1:0] r;
    if (v > 48'sd8388607) r = 24'sh7FFFFF;
    else if (v < -48'sd8388608) r = 24'sh800000;
    else r = v[INNER_W-1:0];
    return r;
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [47:0] round_sh(input logic signed [47:0] v,
                                                  input int unsigned sh);
    logic signed [47:0] r;
    r = (v + (48'sd1 <<< (sh - 1))) >>> sh;
    return r;
  endfunction

endpackage

// ===== design/scar_ifs.sv =====
// Channel interfaces: sample input, result output and register write.
// Depends on scar_pkg for the register port widths.
`timescale 1ns / 1ps

interface scar_in_if #(parameter int SW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_in;
  logic signed [SW-1:0] right_in;
  logic signed [SW-1:0] left_bus;
  logic signed [SW-1:0] right_bus;
  modport source(output valid, left_in, right_in, left_bus, right_bus, input ready);
  modport sink(input valid, left_in, right_in, left_bus, right_bus, output ready);
endinterface

interface scar_out_if #(parameter int SW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_out;
  logic signed [SW-1:0] right_out;
  modport source(output valid, left_out, right_out, input ready);
  modport sink(input valid, left_out, right_out, output ready);
endinterface

interface scar_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [scar_pkg::CFG_IDX_W-1:0]     index;
  logic [scar_pkg::CFG_DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/scar_ctrl.sv =====
// Sequencer for the reverb: walks the clearing pass, comb lines, allpass lines and mix.
// Depends on scar_pkg (command and status types).
`timescale 1ns / 1ps

module scar_ctrl #(
  parameter int COMB_COUNT    = 8,
  parameter int ALLPASS_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scar_pkg::dp_status_t st,
  output scar_pkg::dp_cmd_t    cmd
);

  localparam int NC = 2 * COMB_COUNT;
  localparam int NL = NC + 2 * ALLPASS_COUNT;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001, S_IDLE = 16'h0002, S_CRD = 16'h0004, S_CM1 = 16'h0008,
    S_CM2   = 16'h0010, S_CM3  = 16'h0020, S_CM4 = 16'h0040, S_CWR = 16'h0080,
    S_SAT   = 16'h0100, S_ARD  = 16'h0200, S_AWR = 16'h0400, S_MX1 = 16'h0800,
    S_MX2   = 16'h1000, S_MX3  = 16'h2000, S_MX4 = 16'h4000, S_FIN = 16'h8000
  } state_t;

  state_t                        state, state_next;
  logic [scar_pkg::LINE_W-1:0]   line, line_next;
  scar_pkg::dp_op_t              op;

  always_comb begin
    state_next = state;
    line_next  = line;
    op         = scar_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = scar_pkg::OP_CLR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = scar_pkg::OP_LOAD;
          state_next = S_CRD;
          line_next  = '0;
        end
      end
      S_CRD: begin op = scar_pkg::OP_CRD; state_next = S_CM1; end
      S_CM1: begin op = scar_pkg::OP_CM1; state_next = S_CM2; end
      S_CM2: begin op = scar_pkg::OP_CM2; state_next = S_CM3; end
      S_CM3: begin op = scar_pkg::OP_CM3; state_next = S_CM4; end
      S_CM4: begin op = scar_pkg::OP_CM4; state_next = S_CWR; end
      S_CWR: begin
        op        = scar_pkg::OP_CWR;
        line_next = line + 1'b1;
        if (line == scar_pkg::LINE_W'(NC - 1)) state_next = S_SAT;
        else state_next = S_CRD;
      end
      S_SAT: begin op = scar_pkg::OP_SAT; state_next = S_ARD; end
      S_ARD: begin op = scar_pkg::OP_ARD; state_next = S_AWR; end
      S_AWR: begin
        op        = scar_pkg::OP_AWR;
        line_next = line + 1'b1;
        if (line == scar_pkg::LINE_W'(NL - 1)) state_next = S_MX1;
        else state_next = S_ARD;
      end
      S_MX1: begin op = scar_pkg::OP_MX1; state_next = S_MX2; end
      S_MX2: begin op = scar_pkg::OP_MX2; state_next = S_MX3; end
      S_MX3: begin op = scar_pkg::OP_MX3; state_next = S_MX4; end
      S_MX4: begin op = scar_pkg::OP_MX4; state_next = S_FIN; end
      S_FIN: begin
        op = scar_pkg::OP_FIN;
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      line  <= '0;
    end else begin
      state <= state_next;
      line  <= line_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.line = line;

endmodule

// ===== design/scar_datapath.sv =====
// Reverb datapath: delay memories, filter state, shared multiplier, mix and output register.
// Depends on scar_pkg; driven by scar_ctrl commands.
`timescale 1ns / 1ps

module scar_datapath #(
  parameter int COMB_COUNT    = 8,
  parameter int ALLPASS_COUNT = 4,
  parameter int STEREO_SPREAD = 23,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  scar_pkg::dp_cmd_t                  cmd,
  output scar_pkg::dp_status_t               st,
  input  logic signed [SAMPLE_WIDTH-1:0]     left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]     right_in,
  input  logic signed [SAMPLE_WIDTH-1:0]     left_bus,
  input  logic signed [SAMPLE_WIDTH-1:0]     right_bus,
  input  logic                               cfg_valid,
  input  logic [scar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scar_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]     left_out,
  output logic signed [SAMPLE_WIDTH-1:0]     right_out
);

  localparam int NC   = 2 * COMB_COUNT;
  localparam int NA   = 2 * ALLPASS_COUNT;
  localparam int NL   = NC + NA;
  localparam int CT   = scar_pkg::comb_total(COMB_COUNT, STEREO_SPREAD);
  localparam int AT   = scar_pkg::ap_total(COMB_COUNT, ALLPASS_COUNT, STEREO_SPREAD);
  localparam int CMAX = (CT > AT) ? CT : AT;
  localparam int CAW  = $clog2(CT);
  localparam int AAW  = $clog2(AT);
  localparam int CLW  = $clog2(CMAX);
  localparam int PW   = $clog2(scar_pkg::MAX_BASE + STEREO_SPREAD + 1);
  localparam int LIW  = $clog2(NL);
  localparam int FIW  = $clog2(NC);
  localparam int AW   = scar_pkg::INNER_W + $clog2(COMB_COUNT) + 1;
  localparam int IW   = scar_pkg::INNER_W;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [47:0] v);
    logic signed [47:0]             hi;
    logic signed [47:0]             lo;
    logic signed [SAMPLE_WIDTH-1:0] r;
    hi = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) r = hi[SAMPLE_WIDTH-1:0];
    else if (v < lo) r = lo[SAMPLE_WIDTH-1:0];
    else r = v[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  // configuration
  logic [15:0] room, damping, wet_main, wet_cross;

  // line lengths as constants
  logic [PW-1:0] len_tab [NL];
  for (genvar g = 0; g < NL; g++) begin : g_len
    assign len_tab[g] = PW'(scar_pkg::line_len(g, COMB_COUNT, ALLPASS_COUNT, STEREO_SPREAD));
  end

  // storage
  logic signed [IW-1:0] cmem [CT];
  logic signed [IW-1:0] amem [AT];
  logic signed [IW-1:0] fmem [NC];
  logic [PW-1:0]        pos  [NL];

  logic [CAW-1:0] cbase;
  logic [AAW-1:0] abase;
  logic [CLW-1:0] clr_addr;
  logic           clr_done;

  logic signed [IW-1:0]           mono, crd, ard;
  logic signed [SAMPLE_WIDTH-1:0] bus_l, bus_r, mix_l;
  logic signed [AW-1:0]           acc_l, acc_r;
  logic signed [41:0]             prod, tmp;

  logic [LIW-1:0]  li;
  logic [FIW-1:0]  fi;
  logic            right_comb, right_ap, is_clr;
  logic [PW-1:0]   pos_cur, len_cur, pos_inc, pos_adv;
  logic [CAW-1:0]  caddr;
  logic [AAW-1:0]  aaddr;

  logic signed [IW-1:0]  mul_a;
  logic signed [17:0]    mul_b;
  logic [16:0]           damp_inv;
  logic signed [47:0]    sum48, ap_in48, ard48;
  logic signed [IW-1:0]  fnew, cell_new, ap_wr, ap_out;
  logic signed [SAMPLE_WIDTH-1:0] mix_sat;
  logic signed [SAMPLE_WIDTH:0]   lr_sum;

  assign li         = cmd.line[LIW-1:0];
  assign fi         = cmd.line[FIW-1:0];
  assign right_comb = cmd.line >= scar_pkg::LINE_W'(COMB_COUNT);
  assign right_ap   = cmd.line >= scar_pkg::LINE_W'(NC + ALLPASS_COUNT);
  assign pos_cur    = pos[li];
  assign len_cur    = len_tab[li];
  assign pos_inc    = pos_cur + 1'b1;
  assign pos_adv    = (pos_inc >= len_cur) ? '0 : pos_inc;
  assign caddr      = cbase + CAW'(pos_cur);
  assign aaddr      = abase + AAW'(pos_cur);
  assign is_clr     = (cmd.op == scar_pkg::OP_CLR) && !clr_done;

  assign damp_inv = 17'h10000 - {1'b0, damping};

  // shared multiplier operands
  always_comb begin
    mul_a = crd;
    mul_b = '0;
    case (cmd.op)
      scar_pkg::OP_CM1: begin mul_a = crd;          mul_b = signed'({1'b0, damp_inv}); end
      scar_pkg::OP_CM2: begin mul_a = fmem[fi];     mul_b = signed'({2'b0, damping}); end
      scar_pkg::OP_CM4: begin mul_a = fmem[fi];     mul_b = signed'({2'b0, room}); end
      scar_pkg::OP_MX1: begin mul_a = acc_l[IW-1:0]; mul_b = signed'({2'b0, wet_main}); end
      scar_pkg::OP_MX2: begin mul_a = acc_r[IW-1:0]; mul_b = signed'({2'b0, wet_cross}); end
      scar_pkg::OP_MX3: begin mul_a = acc_r[IW-1:0]; mul_b = signed'({2'b0, wet_main}); end
      scar_pkg::OP_MX4: begin mul_a = acc_l[IW-1:0]; mul_b = signed'({2'b0, wet_cross}); end
      default: ;
    endcase
  end

  assign sum48    = 48'(tmp) + 48'(prod);
  assign fnew     = scar_pkg::sat_inner(scar_pkg::round_sh(sum48, 16));
  assign cell_new = scar_pkg::sat_inner(48'(mono) + scar_pkg::round_sh(48'(prod), 16));
  assign ap_in48  = right_ap ? 48'(acc_r) : 48'(acc_l);
  assign ard48    = 48'(ard);
  assign ap_wr    = scar_pkg::sat_inner(ap_in48 + scar_pkg::round_sh(ard48, 1));
  assign ap_out   = scar_pkg::sat_inner(ard48 - ap_in48);
  assign mix_sat  = sat_out(48'((cmd.op == scar_pkg::OP_MX3) ? bus_l : bus_r)
                            + scar_pkg::round_sh(sum48, 14));
  assign lr_sum   = (SAMPLE_WIDTH + 1)'(left_in) + (SAMPLE_WIDTH + 1)'(right_in);

  // comb delay memory
  always_ff @(posedge clk) begin
    if (is_clr && ({1'b0, clr_addr} < (CLW + 1)'(CT))) cmem[clr_addr[CAW-1:0]] <= '0;
    else if (cmd.op == scar_pkg::OP_CWR) cmem[caddr] <= cell_new;
    if (cmd.op == scar_pkg::OP_CRD) crd <= cmem[caddr];
  end

  // allpass delay memory
  always_ff @(posedge clk) begin
    if (is_clr && ({1'b0, clr_addr} < (CLW + 1)'(AT))) amem[clr_addr[AAW-1:0]] <= '0;
    else if (cmd.op == scar_pkg::OP_AWR) amem[aaddr] <= ap_wr;
    if (cmd.op == scar_pkg::OP_ARD) ard <= amem[aaddr];
  end

  // multiplier pipeline register
  always_ff @(posedge clk) begin
    case (cmd.op)
      scar_pkg::OP_CM1, scar_pkg::OP_CM4, scar_pkg::OP_MX1, scar_pkg::OP_MX3:
        prod <= mul_a * mul_b;
      scar_pkg::OP_CM2, scar_pkg::OP_MX2, scar_pkg::OP_MX4: begin
        tmp  <= prod;
        prod <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      room      <= scar_pkg::ROOM_RESET;
      damping   <= scar_pkg::DAMPING_RESET;
      wet_main  <= scar_pkg::WET_MAIN_RESET;
      wet_cross <= scar_pkg::WET_CROSS_RESET;
      clr_addr  <= '0;
      clr_done  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NL; i++) pos[i] <= '0;
      for (int i = 0; i < NC; i++) fmem[i] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          scar_pkg::REG_ROOM:      room      <= cfg_data;
          scar_pkg::REG_DAMPING:   damping   <= cfg_data;
          scar_pkg::REG_WET_MAIN:  wet_main  <= cfg_data;
          scar_pkg::REG_WET_CROSS: wet_cross <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        scar_pkg::OP_CLR: begin
          if (!clr_done) begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == CLW'(CMAX - 1)) clr_done <= 1'b1;
          end
        end
        scar_pkg::OP_LOAD: begin
          mono  <= IW'(scar_pkg::round_sh(48'(lr_sum) * 48'sd983, 16));
          bus_l <= left_bus;
          bus_r <= right_bus;
          acc_l <= '0;
          acc_r <= '0;
          cbase <= '0;
        end
        scar_pkg::OP_CM3: fmem[fi] <= fnew;
        scar_pkg::OP_CWR: begin
          pos[li] <= pos_adv;
          cbase   <= cbase + CAW'(len_cur);
          if (right_comb) acc_r <= acc_r + AW'(crd);
          else acc_l <= acc_l + AW'(crd);
        end
        scar_pkg::OP_SAT: begin
          acc_l <= AW'(scar_pkg::sat_inner(48'(acc_l)));
          acc_r <= AW'(scar_pkg::sat_inner(48'(acc_r)));
          abase <= '0;
        end
        scar_pkg::OP_AWR: begin
          pos[li] <= pos_adv;
          abase   <= abase + AAW'(len_cur);
          if (right_ap) acc_r <= AW'(ap_out);
          else acc_l <= AW'(ap_out);
        end
        scar_pkg::OP_MX3: mix_l <= mix_sat;
        scar_pkg::OP_FIN: begin
          if (!out_valid) begin
            left_out  <= mix_l;
            right_out <= mix_sat;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign st.clr_done = clr_done;
  assign st.out_busy = out_valid;

  // a new result shows up only from the final mix step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == scar_pkg::OP_FIN))
    else $error("result raised outside final mix step");

  // comb writes address comb lines only
  a_comb_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == scar_pkg::OP_CWR) |-> (cmd.line < scar_pkg::LINE_W'(NC)))
    else $error("comb write on non-comb line");

  // allpass writes address allpass lines only
  a_ap_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == scar_pkg::OP_AWR) |->
      (cmd.line >= scar_pkg::LINE_W'(NC) && cmd.line < scar_pkg::LINE_W'(NL)))
    else $error("allpass write on non-allpass line");

  // delay position stays inside its line
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == scar_pkg::OP_CWR || cmd.op == scar_pkg::OP_AWR) |-> (pos_cur < len_cur))
    else $error("delay position beyond line length");

endmodule

// ===== design/stereo_comb_allpass_reverb_unit.sv =====
// Items are handled one at a time: input is accepted only in idle, and each item walks
//   the comb lines (read, CM1 to CM4, write), a saturation step, the allpass lines
//   (read, write) and the mix steps MX1 to MX4 on one shared multiplier and single-port
//   delay memories; the final step registers the result once the previous one is taken.
// Reset: synchronous, active high; then a clearing pass over max(comb, allpass) store
//   depth zeroes the delay memories while input is held off.
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_unit #(
  parameter int COMB_COUNT    = 8,
  parameter int ALLPASS_COUNT = 4,
  parameter int STEREO_SPREAD = 23,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  scar_in_if.sink     in_ch,
  scar_out_if.source  out_ch,
  scar_cfg_if.sink    cfg_ch
);

  // controller <-> datapath
  scar_pkg::dp_cmd_t    cmd;
  scar_pkg::dp_status_t st;
  logic                 in_ready;

  // registers always writable; the host writes only while the block is idle (not enforced here)
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // sequencer: clear pass, per-line comb and allpass steps, wet mix
  scar_ctrl #(
    .COMB_COUNT   (COMB_COUNT),
    .ALLPASS_COUNT(ALLPASS_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  // delay memories, filter state, shared multiplier, output register
  scar_datapath #(
    .COMB_COUNT   (COMB_COUNT),
    .ALLPASS_COUNT(ALLPASS_COUNT),
    .STEREO_SPREAD(STEREO_SPREAD),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .left_in  (in_ch.left_in),
    .right_in (in_ch.right_in),
    .left_bus (in_ch.left_bus),
    .right_bus(in_ch.right_bus),
    .cfg_valid(cfg_ch.valid),
    .cfg_index(cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .left_out (out_ch.left_out),
    .right_out(out_ch.right_out)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for stereo_comb_allpass_reverb_unit.
// Depends on scar_pkg and the channel interfaces in scar_ifs.sv; an internal fixed-point
// reverb model predicts each output item, and the monitor compares it field by field.
`timescale 1ns / 1ps

module tb;

  localparam int NCOMB = 8;
  localparam int NAP = 4;
  localparam int SPREAD = 23;
  localparam int SW = 16;
  localparam int NLINES = 2 * NCOMB + 2 * NAP;
  localparam int COMB_DEPTH = 22232;
  localparam int AP_DEPTH = 3218;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;
  // index past the register list
  localparam logic [scar_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  typedef struct packed {
    logic signed [SW-1:0] l, r, lb, rb;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] l, r;
  } mix_t;

  logic clk = 0;
  logic rst = 1;

  scar_in_if #(SW) in_ch();
  scar_out_if #(SW) out_ch();
  scar_cfg_if cfg_ch();

  stereo_comb_allpass_reverb_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial forever #5 clk = ~clk;

  // model state: config plus delay lines
  longint room_fb, damp, g_main, g_cross;
  longint comb_mem [COMB_DEPTH];
  longint lp_mem [2*NCOMB];
  longint ap_mem [AP_DEPTH];
  int pos [NLINES];
  int llen [NLINES];
  int loff [NLINES];

  sample_t pending[$];
  mix_t expected_mix[$];
  int failures = 0;
  longint cycles = 0;
  bit idle_off = 0;
  bit long_hold = 0;

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic model_reset();
    int o;
    room_fb = scar_pkg::ROOM_RESET; damp = scar_pkg::DAMPING_RESET;
    g_main = scar_pkg::WET_MAIN_RESET; g_cross = scar_pkg::WET_CROSS_RESET;
    foreach (comb_mem[i]) comb_mem[i] = 0;
    foreach (ap_mem[i]) ap_mem[i] = 0;
    foreach (lp_mem[i]) lp_mem[i] = 0;
    o = 0;
    for (int i = 0; i < 2*NCOMB; i++) begin
      llen[i] = scar_pkg::COMB_BASE[i % NCOMB] + (i >= NCOMB ? SPREAD : 0);
      loff[i] = o; o += llen[i]; pos[i] = 0;
    end
    o = 0;
    for (int i = 0; i < 2*NAP; i++) begin
      llen[2*NCOMB+i] = scar_pkg::AP_BASE[i % NAP] + (i >= NAP ? SPREAD : 0);
      loff[2*NCOMB+i] = o; o += llen[2*NCOMB+i]; pos[2*NCOMB+i] = 0;
    end
  endtask

  function automatic void step_line(int ln);
    pos[ln] = (pos[ln] + 1 >= llen[ln]) ? 0 : pos[ln] + 1;
  endfunction

  function automatic longint comb_tap(int k, longint x);
    int a;
    longint y, m;
    a = loff[k] + pos[k];
    y = comb_mem[a];
    m = clip(rnd_sh(y * (65536 - damp) + lp_mem[k] * damp, 16), 24);
    lp_mem[k] = m;
    comb_mem[a] = clip(x + rnd_sh(m * room_fb, 16), 24);
    step_line(k);
    return y;
  endfunction

  function automatic longint allpass_tap(int k, longint x);
    int ln, a;
    longint b;
    ln = 2*NCOMB + k;
    a = loff[ln] + pos[ln];
    b = ap_mem[a];
    ap_mem[a] = clip(x + rnd_sh(b, 1), 24);
    step_line(ln);
    return clip(b - x, 24);
  endfunction

  function automatic mix_t reverb_predict(sample_t s);
    longint mono, al, ar, ml, mr;
    mix_t m;
    mono = rnd_sh((longint'(s.l) + longint'(s.r)) * scar_pkg::MONO_GAIN, 16);
    al = 0; ar = 0;
    for (int i = 0; i < NCOMB; i++) begin
      al += comb_tap(i, mono);
      ar += comb_tap(NCOMB + i, mono);
    end
    al = clip(al, 24); ar = clip(ar, 24);
    for (int i = 0; i < NAP; i++) begin
      al = allpass_tap(i, al);
      ar = allpass_tap(NAP + i, ar);
    end
    ml = rnd_sh(al * g_main + ar * g_cross, 14);
    mr = rnd_sh(ar * g_main + al * g_cross, 14);
    m.l = SW'(clip(longint'(s.lb) + ml, SW));
    m.r = SW'(clip(longint'(s.rb) + mr, SW));
    return m;
  endfunction

  // cycle counter / timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // input driver: random idle bursts, prediction at each accepted item
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_mix.push_back(reverb_predict({in_ch.left_in, in_ch.right_in,
                                               in_ch.left_bus, in_ch.right_bus}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 0;
        end else if (pending.size() > 0) begin
          sample_t s;
          s = pending.pop_front();
          in_ch.valid <= 1;
          in_ch.left_in <= s.l; in_ch.right_in <= s.r;
          in_ch.left_bus <= s.lb; in_ch.right_bus <= s.rb;
          if (!idle_off && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 19);
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // output monitor with random stalls and one long hold-off
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_mix.size() == 0) begin
          $display("%0t: unexpected item L=%0d R=%0d", $time, out_ch.left_out,
                   out_ch.right_out);
          failures++;
        end else begin
          mix_t e;
          e = expected_mix.pop_front();
          if (out_ch.left_out !== e.l) begin
            $display("%0t: left_out expected %0d actual %0d", $time, e.l, out_ch.left_out);
            failures++;
          end
          if (out_ch.right_out !== e.r) begin
            $display("%0t: right_out expected %0d actual %0d", $time, e.r, out_ch.right_out);
            failures++;
          end
        end
      end
      if (long_hold && hold_cnt < 3000) begin
        hold_cnt <= hold_cnt + 1;
        out_ch.ready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        if (!idle_off && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 19);
      end
    end
  end

  // one register write; valid drops for a cycle before the next write
  task automatic cfg_write(logic [scar_pkg::CFG_IDX_W-1:0] idx,
                           logic [scar_pkg::CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    if (idx == scar_pkg::REG_ROOM) room_fb = v;
    else if (idx == scar_pkg::REG_DAMPING) damp = v;
    else if (idx == scar_pkg::REG_WET_MAIN) g_main = v;
    else if (idx == scar_pkg::REG_WET_CROSS) g_cross = v;
    @(posedge clk);
  endtask

  // wait until all queued items are out, then let the pipeline drain;
  // checked at the falling edge so the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (pending.size() > 0 || in_ch.valid || expected_mix.size() > 0) @(negedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] edge_val();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic push_random(int n, bit loud);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.l = loud ? edge_val() : SW'($urandom); s.r = loud ? edge_val() : SW'($urandom);
      s.lb = SW'($urandom); s.rb = SW'($urandom);
      pending.push_back(s);
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.left_in = 0; in_ch.right_in = 0;
    in_ch.left_bus = 0; in_ch.right_bus = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: field extremes, bus saturation both ways, silence
    pending.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    pending.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending.push_back('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000});
    pending.push_back('{16'sh0000, 16'sh0000, 16'shFFFF, 16'sh0001});
    for (int i = 0; i < 12; i++) pending.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FF0, 16'sh8010});
    drain();

    // max feedback, no damping, full wet gains: saturation inside and at the output
    cfg_write(scar_pkg::REG_ROOM, 16'hFFFF);
    cfg_write(scar_pkg::REG_DAMPING, 16'h0000);
    cfg_write(scar_pkg::REG_WET_MAIN, 16'hFFFF);
    cfg_write(scar_pkg::REG_WET_CROSS, 16'hFFFF);
    cfg_write(REG_UNUSED, 16'h1234);  // index past the register list: ignored
    push_random(200, 1);
    drain();

    // zero gains and full damping
    cfg_write(scar_pkg::REG_ROOM, 16'h0000);
    cfg_write(scar_pkg::REG_DAMPING, 16'hFFFF);
    cfg_write(scar_pkg::REG_WET_MAIN, 16'h0000);
    cfg_write(scar_pkg::REG_WET_CROSS, 16'h0000);
    push_random(100, 0);
    // long receiver hold-off while the sender keeps offering items
    long_hold = 1;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      cfg_write(scar_pkg::REG_ROOM, scar_pkg::CFG_DATA_W'($urandom));
      cfg_write(scar_pkg::REG_DAMPING, scar_pkg::CFG_DATA_W'($urandom));
      cfg_write(scar_pkg::REG_WET_MAIN, scar_pkg::CFG_DATA_W'($urandom));
      cfg_write(scar_pkg::REG_WET_CROSS, scar_pkg::CFG_DATA_W'($urandom));
      push_random(130, ph == 1);
      drain();
    end

    // typical settings, no idling at the end
    cfg_write(scar_pkg::REG_ROOM, scar_pkg::ROOM_RESET);
    cfg_write(scar_pkg::REG_DAMPING, scar_pkg::DAMPING_RESET);
    cfg_write(scar_pkg::REG_WET_MAIN, scar_pkg::WET_MAIN_RESET);
    cfg_write(scar_pkg::REG_WET_CROSS, 16'd4096);
    idle_off = 1;
    push_random(140, 0);
    drain();

    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
